@@ rtl/sorted_priority_queue_core_macros.svh @@
// Assertion macros shared by the sorted priority queue design.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

@@ rtl/spq_pkg.sv @@
// Types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_CNT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [15:0] customer;
        logic [23:0] amount;
        logic [2:0]  prio;
    } spq_entry_t;

    // Broadcast to every cell for one accepted beat.
    typedef struct packed {
        logic       ins;
        logic       pop;
        spq_entry_t item;
    } spq_cmd_t;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic       valid;
        spq_entry_t entry;
    } spq_link_t;

endpackage

@@ rtl/spq_cell.sv @@
// One slot of the queue: compares against the new entry and shifts with its neighbors.
`timescale 1ns / 1ps
module spq_cell import spq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  spq_cmd_t   cmd,
    input  logic       head_slot,
    input  spq_link_t  left_link,
    input  logic       left_ahead,
    input  spq_link_t  right_link,
    output spq_link_t  link,
    output logic       ahead,
    output spq_entry_t next_entry
);

    spq_entry_t entry_reg, entry_next;
    logic       valid_reg, valid_next;

    // The head slot also counts an equal priority as ahead of the new entry,
    // so a new entry never displaces a head of the same priority.
    assign ahead = valid_reg &&
                   ((entry_reg.prio < cmd.item.prio) ||
                    (head_slot && (entry_reg.prio == cmd.item.prio)));

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (cmd.pop) begin
            entry_next = right_link.entry;
            valid_next = right_link.valid;
        end else if (cmd.ins && !ahead) begin
            if (left_ahead) begin
                entry_next = cmd.item;
                valid_next = 1'b1;
            end else begin
                entry_next = left_link.entry;
                valid_next = left_link.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign link       = {valid_reg, entry_reg};
    assign next_entry = entry_next;

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
// The result beat is registered and is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while m_ready is high; every cell compares and
// shifts in the same cycle, so the row of cells sets no extra wait.
// Reset: clears the entry count, the cell valid bits and the result valid flag;
// slot contents and result fields are not cleared and are ignored until written.
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_macros.svh"
module sorted_priority_queue_core import spq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic [15:0]            s_customer_id,
    input  logic [23:0]            s_amount,
    input  logic [2:0]             s_priority_level,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output logic                   m_head_valid,
    output logic [15:0]            m_head_customer,
    output logic [23:0]            m_head_amount,
    output logic [2:0]             m_head_priority,
    output logic [ENTRY_CNT_W-1:0] m_entry_count
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    logic [1:0]       status_reg, status_next;
    logic             head_valid_reg;
    spq_entry_t       head_reg, head_next;
    logic [CNT_W-1:0] out_count_reg;

    logic       accept, full, empty;
    spq_cmd_t   cmd;
    spq_link_t  cell_link [QUEUE_DEPTH];
    logic       cell_ahead [QUEUE_DEPTH];
    spq_entry_t cell_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);

    always_comb begin
        cmd.ins           = accept && (s_opcode == OP_INSERT) && !full;
        cmd.pop           = accept && (s_opcode == OP_POP) && !empty;
        cmd.item.customer = s_customer_id;
        cmd.item.amount   = s_amount;
        cmd.item.prio     = s_priority_level;
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            spq_link_t left_l, right_l;
            logic      left_b;
            if (gi == 0) begin : g_first
                assign left_l = {1'b0, cmd.item};
                assign left_b = 1'b1;
            end else begin : g_mid
                assign left_l = cell_link[gi-1];
                assign left_b = cell_ahead[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign right_l = '0;
            end else begin : g_inner
                assign right_l = cell_link[gi+1];
            end
            spq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .head_slot   (gi == 0),
                .left_link   (left_l),
                .left_ahead  (left_b),
                .right_link  (right_l),
                .link        (cell_link[gi]),
                .ahead       (cell_ahead[gi]),
                .next_entry  (cell_next[gi])
            );
            assign cell_valid[gi] = cell_link[gi].valid;
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
        status_next = ST_DONE;
        if (s_opcode == OP_INSERT && full) begin
            status_next = ST_FULL;
        end else if (s_opcode == OP_POP && empty) begin
            status_next = ST_EMPTY;
        end
        head_next = (count_next != '0) ? cell_next[0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg     <= status_next;
            head_valid_reg <= (count_next != '0);
            head_reg       <= head_next;
            out_count_reg  <= count_next;
        end
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_head_valid    = head_valid_reg;
    assign m_head_customer = head_reg.customer;
    assign m_head_amount   = head_reg.amount;
    assign m_head_priority = head_reg.prio;
    assign m_entry_count   = ENTRY_CNT_W'(out_count_reg);

    // The valid bits of the cells always form the held count.
    `SPQ_ASSERT_IMP(a_valid_count, aclk, aresetn, 1'b1, $countones(cell_valid) == count_reg)
    // The two front cells stay in priority order.
    `SPQ_ASSERT_IMP(a_front_sorted, aclk, aresetn, cell_link[1].valid, cell_link[0].entry.prio <= cell_link[1].entry.prio)
    // A refused insert is reported as such and leaves the count alone.
    `SPQ_ASSERT_NXT(a_full_refused, aclk, aresetn, accept && (s_opcode == OP_INSERT) && full, (m_status == ST_FULL) && (count_reg == CNT_W'(QUEUE_DEPTH)))
    // The reported head is valid exactly when the queue holds entries.
    `SPQ_ASSERT_IMP(a_head_valid, aclk, aresetn, m_valid_reg, m_head_valid == (count_reg != '0))

endmodule

@@ test/tb_sorted_priority_queue_core.sv @@
// Testbench for sorted_priority_queue_core: directed and random beats checked against a scoreboard.
`timescale 1ns / 1ps
module tb_sorted_priority_queue_core;
    import spq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 643;

    typedef struct packed {
        logic [1:0]             status;
        logic                   head_valid;
        logic [15:0]            head_customer;
        logic [23:0]            head_amount;
        logic [2:0]             head_priority;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } report_t;

    class queue_scoreboard;
        logic [15:0] slot_cust [QUEUE_DEPTH];
        logic [23:0] slot_amt  [QUEUE_DEPTH];
        logic [2:0]  slot_prio [QUEUE_DEPTH];
        int          held;
        report_t     pending_reports[$];
        int          mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function report_t predict_report(logic op, logic [15:0] cust, logic [23:0] amt,
                                         logic [2:0] prio);
            report_t r;
            int pos;
            r.status = ST_DONE;
            if (op == OP_INSERT) begin
                if (held >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    for (int i = 0; i < held; i++)
                        if (slot_prio[i] < prio) pos++;
                    // An equal number at the head never displaces the head.
                    if (pos == 0 && held > 0 && slot_prio[0] == prio) pos = 1;
                    for (int i = held; i > pos; i--) begin
                        slot_cust[i] = slot_cust[i-1];
                        slot_amt[i]  = slot_amt[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_cust[pos] = cust;
                    slot_amt[pos]  = amt;
                    slot_prio[pos] = prio;
                    held++;
                end
            end else if (held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                for (int i = 0; i + 1 < held; i++) begin
                    slot_cust[i] = slot_cust[i+1];
                    slot_amt[i]  = slot_amt[i+1];
                    slot_prio[i] = slot_prio[i+1];
                end
                held--;
            end
            if (held > 0) begin
                r.head_valid    = 1'b1;
                r.head_customer = slot_cust[0];
                r.head_amount   = slot_amt[0];
                r.head_priority = slot_prio[0];
            end else begin
                r.head_valid    = 1'b0;
                r.head_customer = '0;
                r.head_amount   = '0;
                r.head_priority = '0;
            end
            r.entry_count = ENTRY_CNT_W'(held);
            return r;
        endfunction

        function void note_request(logic op, logic [15:0] cust, logic [23:0] amt,
                                   logic [2:0] prio);
            pending_reports.push_back(predict_report(op, cust, amt, prio));
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status=%0d cnt=%0d",
                             got.status, got.entry_count);
                return;
            end
            want = pending_reports.pop_front();
            if (got.status !== want.status || got.head_valid !== want.head_valid ||
                got.head_customer !== want.head_customer ||
                got.head_amount !== want.head_amount ||
                got.head_priority !== want.head_priority ||
                got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected st=%0d hv=%0d cust=%h amt=%h pri=%0d cnt=%0d",
                             want.status, want.head_valid, want.head_customer,
                             want.head_amount, want.head_priority, want.entry_count);
                    $display("                 got      st=%0d hv=%0d cust=%h amt=%h pri=%0d cnt=%0d",
                             got.status, got.head_valid, got.head_customer,
                             got.head_amount, got.head_priority, got.entry_count);
                end
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_opcode = OP_INSERT;
    logic [15:0]            s_customer_id = '0;
    logic [23:0]            s_amount = '0;
    logic [2:0]             s_priority_level = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_status;
    logic                   m_head_valid;
    logic [15:0]            m_head_customer;
    logic [23:0]            m_head_amount;
    logic [2:0]             m_head_priority;
    logic [ENTRY_CNT_W-1:0] m_entry_count;

    queue_scoreboard sb = new();
    int s_idle_pct = 23;
    int m_idle_pct = 64;
    int stall_cycles = 0;

    sorted_priority_queue_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_customer_id    (s_customer_id),
        .s_amount         (s_amount),
        .s_priority_level (s_priority_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_head_valid     (m_head_valid),
        .m_head_customer  (m_head_customer),
        .m_head_amount    (m_head_amount),
        .m_head_priority  (m_head_priority),
        .m_entry_count    (m_entry_count)
    );

    always #4 aclk = ~aclk;

    // Result side: check each accepted beat, then pick the next ready level.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_report({m_status, m_head_valid, m_head_customer, m_head_amount,
                                 m_head_priority, m_entry_count});
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_sorted_priority_queue_core: FAIL");
            $finish;
        end
    end

    task automatic send_beat(logic op, logic [15:0] cust, logic [23:0] amt, logic [2:0] prio);
        // Each cycle the sender idles with the given chance before offering the beat.
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_customer_id    <= cust;
        s_amount         <= amt;
        s_priority_level <= prio;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, cust, amt, prio);
    endtask

    // Hold the input side off until every outstanding result beat has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_reports.size() != 0);
    endtask

    task automatic send_random(int insert_pct);
        logic        op;
        logic [15:0] cust;
        logic [23:0] amt;
        logic [2:0]  prio;
        op   = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
        cust = 16'($urandom());
        amt  = 24'($urandom());
        if ($urandom_range(9) == 0) cust = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(9) == 0) amt = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        // Mostly the documented one to four, so ties are common; sometimes any 3-bit value.
        prio = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
        send_beat(op, cust, amt, prio);
    endtask

    task automatic run_phase(int items);
        int sent;
        int run_len;
        int bias;
        sent = 0;
        while (sent < items) begin
            // Runs that lean toward inserts fill the queue, those toward pops drain it.
            run_len = $urandom_range(10, 60);
            case ($urandom_range(2))
                0: bias = 85;
                1: bias = 50;
                default: bias = 15;
            endcase
            for (int i = 0; i < run_len && sent < items; i++) begin
                send_random(bias);
                sent++;
            end
        end
    endtask

    initial begin
        logic [2:0] dir_prio [16];
        dir_prio = '{3'd1, 3'd4, 3'd4, 3'd2, 3'd1, 3'd0, 3'd7, 3'd3,
                     3'd1, 3'd2, 3'd5, 3'd6, 3'd4, 3'd0, 3'd3, 3'd1};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(OP_POP, 16'hFFFF, 24'hFFFFFF, 3'd7);
        send_beat(OP_INSERT, 16'h0000, 24'h000000, dir_prio[0]);
        send_beat(OP_INSERT, 16'hFFFF, 24'hFFFFFF, dir_prio[1]);
        for (int i = 2; i < QUEUE_DEPTH; i++)
            send_beat(OP_INSERT, 16'(16'h1000 * i + i), 24'(24'h010101 * i), dir_prio[i]);
        // Queue is full now; a better priority must still be refused.
        send_beat(OP_INSERT, 16'hABCD, 24'h123456, 3'd0);
        repeat (3) send_beat(OP_POP, 16'($urandom()), 24'($urandom()), 3'($urandom_range(7)));
        wait_drained();

        run_phase(PHASE_ITEMS);
        wait_drained();
        s_idle_pct = 64;
        m_idle_pct = 23;
        run_phase(PHASE_ITEMS);
        s_idle_pct = 0;
        m_idle_pct = 0;
        run_phase(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
            $display("tb_sorted_priority_queue_core: PASS");
        else
            $display("tb_sorted_priority_queue_core: FAIL");
        $finish;
    end

endmodule
